[src/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the HEX record parser
// Character codes, record types, result kinds, the parser state record and
// the hex digit decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [7:0] TYPE_DATA    = 8'd0;
  localparam logic [7:0] TYPE_EOF     = 8'd1;
  localparam logic [7:0] TYPE_EXT_SEG = 8'd2;
  localparam logic [7:0] TYPE_EXT_LIN = 8'd4;
  localparam logic [7:0] EXT_LEN      = 8'd2;

  // Header is eight digits; a line needs header plus checksum at minimum.
  localparam logic [9:0] HDR_NIBBLES = 10'd8;
  localparam logic [9:0] LINE_MIN    = 10'd10;
  localparam logic [9:0] FIRST_DATA  = 10'd9;
  localparam logic [9:0] MAX_NIBBLES = 10'd520;

  localparam logic [31:0] EXT_WRAP = 32'h6000_0000;

  typedef enum logic [1:0] {
    PH_COLON,
    PH_REC,
    PH_EXT_BAD,
    PH_EXT_DONE
  } phase_t;

  typedef enum logic [1:0] {
    FIN_RUN,
    FIN_END,
    FIN_ERR
  } finish_t;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_DROP    = 3'd1,
    KIND_OK      = 3'd2,
    KIND_IGNORED = 3'd3,
    KIND_END     = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [9:0]  nibble_count;
    logic [3:0]  high_nibble;
    logic [7:0]  record_length;
    logic [15:0] record_address;
    logic [7:0]  record_type;
    logic [7:0]  running_sum;
    logic [15:0] field_value;
    logic [31:0] ext_base;
    logic [31:0] byte_total;
    finish_t     finished;
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [31:0] total_bytes;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_COLON,
    nibble_count:   10'd0,
    high_nibble:    4'd0,
    record_length:  8'd0,
    record_address: 16'd0,
    record_type:    8'd0,
    running_sum:    8'd0,
    field_value:    16'd0,
    ext_base:       32'd0,
    byte_total:     32'd0,
    finished:       FIN_RUN
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  // Upper and lower case letters share the low nibble offset of nine.
  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      d.value = c[3:0] + 4'd9;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

[src/ihex_char_if.sv]
// ----------------------------------------------------------------------------
// ihex_char_if: character channel
// Carries one ASCII character per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

[src/ihex_result_if.sv]
// ----------------------------------------------------------------------------
// ihex_result_if: parser result channel
// Carries one result word (kind, address, data, running byte total).
// ----------------------------------------------------------------------------
interface ihex_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] address;
  logic [7:0]  data;
  logic [31:0] total_bytes;

  modport source (output valid, output kind, output address, output data,
                  output total_bytes, input ready);
  modport sink (input valid, input kind, input address, input data,
                input total_bytes, output ready);
endinterface

[src/ihex_step.sv]
// ----------------------------------------------------------------------------
// ihex_step: one-character parser step
// Works out the next parser state and the optional result for one character.
// ----------------------------------------------------------------------------
module ihex_step #(
  parameter logic [31:0] MEMORY_BYTES = 32'd262144
) (
  input  ihex_pkg::state_t  cur,
  input  logic [7:0]        ch,
  output ihex_pkg::state_t  nxt,
  output logic              res_valid,
  output ihex_pkg::result_t res
);

  always_comb begin
    logic [9:0]        p;
    logic [9:0]        req;
    logic              ext;
    ihex_pkg::digit_t  d;
    logic              go;
    logic [7:0]        b;
    logic [9:0]        off;
    logic [8:0]        k;
    logic [7:0]        sum_b;
    logic [31:0]       a;
    logic [32:0]       tsum;
    logic [31:0]       nb;

    p     = cur.nibble_count;
    req   = ihex_pkg::LINE_MIN + {1'b0, cur.record_length, 1'b0};
    ext   = ((cur.record_type == ihex_pkg::TYPE_EXT_SEG) ||
             (cur.record_type == ihex_pkg::TYPE_EXT_LIN)) &&
            (cur.record_length == ihex_pkg::EXT_LEN);
    d     = ihex_pkg::hex_digit(ch);
    go    = 1'b0;
    b     = {cur.high_nibble, d.value};
    off   = p - ihex_pkg::FIRST_DATA;
    k     = off[9:1];
    sum_b = cur.running_sum + b;
    a     = cur.ext_base + {16'd0, cur.record_address} + {23'd0, k};
    tsum  = {1'b0, cur.byte_total} + {25'd0, b};
    nb    = (cur.record_type == ihex_pkg::TYPE_EXT_SEG) ?
            {12'd0, cur.field_value, 4'd0} : {cur.field_value, 16'd0};
    if (nb >= ihex_pkg::EXT_WRAP) begin
      nb = nb - ihex_pkg::EXT_WRAP;
    end

    nxt             = cur;
    res_valid       = 1'b0;
    res.kind        = ihex_pkg::KIND_OK;
    res.address     = 32'd0;
    res.data        = 8'd0;
    res.total_bytes = cur.byte_total;

    if (cur.finished != ihex_pkg::FIN_RUN) begin
      // Parsing is over: characters are swallowed silently.
    end else if (cur.phase == ihex_pkg::PH_COLON) begin
      if (ch != ihex_pkg::CH_COLON) begin
        nxt.finished = ihex_pkg::FIN_ERR;
        res_valid    = 1'b1;
        res.kind     = ihex_pkg::KIND_ERROR;
      end else begin
        nxt                = ihex_pkg::STATE_RESET;
        nxt.phase          = ihex_pkg::PH_REC;
        nxt.ext_base       = cur.ext_base;
        nxt.byte_total     = cur.byte_total;
      end
    end else if (ch == ihex_pkg::CH_LF) begin
      res_valid = 1'b1;
      if ((p < ihex_pkg::LINE_MIN) || (p < req)) begin
        nxt.finished = ihex_pkg::FIN_ERR;
        res.kind     = ihex_pkg::KIND_ERROR;
      end else begin
        nxt.phase = ihex_pkg::PH_COLON;
        if (cur.record_type == ihex_pkg::TYPE_DATA) begin
          res.kind = ihex_pkg::KIND_OK;
        end else if (cur.record_type == ihex_pkg::TYPE_EOF) begin
          nxt.finished = ihex_pkg::FIN_END;
          res.kind     = ihex_pkg::KIND_END;
        end else if (ext && (cur.phase == ihex_pkg::PH_EXT_DONE)) begin
          res.kind = ihex_pkg::KIND_OK;
        end else begin
          res.kind = ihex_pkg::KIND_IGNORED;
        end
      end
    end else if ((p < ihex_pkg::HDR_NIBBLES) || (p < req)) begin
      nxt.nibble_count = p + 10'd1;
      if ((p < ihex_pkg::HDR_NIBBLES) || (cur.record_type == ihex_pkg::TYPE_DATA)) begin
        if (!d.ok) begin
          nxt.finished = ihex_pkg::FIN_ERR;
          res_valid    = 1'b1;
          res.kind     = ihex_pkg::KIND_ERROR;
        end else begin
          go = 1'b1;
        end
      end else if (ext && (cur.phase != ihex_pkg::PH_EXT_BAD)) begin
        if (!d.ok) begin
          nxt.phase = ihex_pkg::PH_EXT_BAD;
        end else begin
          go = 1'b1;
        end
      end

      if (go) begin
        if (!p[0]) begin
          nxt.high_nibble = d.value;
        end else if (p < ihex_pkg::HDR_NIBBLES) begin
          nxt.running_sum = sum_b;
          case (p[2:1])
            2'd0: nxt.record_length = b;
            2'd1: nxt.record_address = {b, 8'd0};
            2'd2: nxt.record_address = {cur.record_address[15:8], b};
            default: begin
              nxt.record_type = b;
              if (b == ihex_pkg::TYPE_DATA) begin
                tsum = {1'b0, cur.byte_total} + {25'd0, cur.record_length};
                nxt.byte_total = tsum[32] ? '1 : tsum[31:0];
              end
            end
          endcase
        end else if (k < {1'b0, cur.record_length}) begin
          nxt.running_sum = sum_b;
          if (cur.record_type == ihex_pkg::TYPE_DATA) begin
            res_valid   = 1'b1;
            res.kind    = (a >= MEMORY_BYTES) ? ihex_pkg::KIND_DROP : ihex_pkg::KIND_WRITE;
            res.address = a;
            res.data    = b;
          end else begin
            nxt.field_value = {cur.field_value[7:0], b};
          end
        end else if (sum_b != 8'd0) begin
          if (cur.record_type == ihex_pkg::TYPE_DATA) begin
            nxt.finished = ihex_pkg::FIN_ERR;
            res_valid    = 1'b1;
            res.kind     = ihex_pkg::KIND_ERROR;
          end else begin
            nxt.phase = ihex_pkg::PH_EXT_BAD;
          end
        end else if (ext) begin
          nxt.ext_base = nb;
          nxt.phase    = ihex_pkg::PH_EXT_DONE;
        end
      end
    end
  end

endmodule

[src/ihex_out_stage.sv]
// ----------------------------------------------------------------------------
// ihex_out_stage: result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ihex_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                res_valid,
  input  ihex_pkg::result_t   res,
  output logic                free,
  ihex_result_if.source       results
);

  logic              valid;
  ihex_pkg::result_t payload;

  assign free = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take && res_valid) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      payload <= res;
    end
  end

  assign results.valid       = valid;
  assign results.kind        = payload.kind;
  assign results.address     = payload.address;
  assign results.data        = payload.data;
  assign results.total_bytes = payload.total_bytes;

endmodule

[src/intel_hex_record_parser.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_parser: streaming HEX record parser
// Parses HEX text one character per word and reports writes and record status.
// ----------------------------------------------------------------------------
// The text channel takes one ASCII character per word; LF closes a line. The
// results channel gives at most one word per character: a write or dropped
// byte as each data byte completes, a status word when a line closes, or a
// sticky error word. After an end record or an error, characters are still
// accepted but give nothing until reset.
// A character is captured in the input register, is parsed by the step logic
// and its result word lands in the result register. The block takes one
// character per cycle for as long as the receiver keeps up; the only feedback
// loop is the parser state update.
// When the receiver stalls, the result register holds its word and the input
// register takes one more character only if it is empty; the text channel's
// ready then stays low until the result word is taken.
// Reset (rst, synchronous) empties both registers, clears the extended base
// and the byte total, and puts the parser back to waiting for a colon.
// ----------------------------------------------------------------------------
module intel_hex_record_parser #(
  parameter logic [31:0] MEMORY_BYTES = 32'd262144
) (
  input  logic          clk,
  input  logic          rst,
  ihex_char_if.sink     text,
  ihex_result_if.source results
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_ch;

  // Parser state and step results.
  ihex_pkg::state_t  state;
  ihex_pkg::state_t  state_next;
  logic              step_valid;
  ihex_pkg::result_t step_res;

  logic out_free;
  logic advance;

  // A held character moves on when the result register has room for its word.
  assign advance    = in_valid && out_free;
  assign text.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_ch <= text.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihex_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  ihex_step #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_step (
    .cur       (state),
    .ch        (in_ch),
    .nxt       (state_next),
    .res_valid (step_valid),
    .res       (step_res)
  );

  ihex_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (advance),
    .res_valid (step_valid),
    .res       (step_res),
    .free      (out_free),
    .results   (results)
  );

  // Once parsing has ended, no further result may be produced.
  a_quiet_after_finish : assert property (@(posedge clk) disable iff (rst)
    (state.finished != ihex_pkg::FIN_RUN) |-> !step_valid)
    else $error("result produced after parsing finished");

  // The finished state is sticky until reset.
  a_finish_sticky : assert property (@(posedge clk) disable iff (rst)
    (state.finished != ihex_pkg::FIN_RUN) |=> (state.finished != ihex_pkg::FIN_RUN))
    else $error("finished state cleared without reset");

  // A write is only ever issued inside the memory.
  a_write_in_range : assert property (@(posedge clk) disable iff (rst)
    (step_valid && (step_res.kind == ihex_pkg::KIND_WRITE)) |->
      (step_res.address < MEMORY_BYTES))
    else $error("write issued outside the memory");

  // The digit counter never runs past the longest possible record.
  a_nibble_bound : assert property (@(posedge clk) disable iff (rst)
    state.nibble_count <= ihex_pkg::MAX_NIBBLES)
    else $error("digit counter beyond longest record");

endmodule
